// ----- hdl/rrps_pkg.sv -----
`timescale 1ns / 1ps

package rrps_pkg;

  localparam int NUM_SLOTS = 8;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);
  localparam int WORD_W    = 16;

  localparam logic [WORD_W-1:0] QUANTUM_RST = 16'd100;
  localparam logic [WORD_W-1:0] STACK_RST   = 16'hFF00;
  localparam logic [WORD_W-1:0] FIRST_SEG   = 16'h2000;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  // register select, taken from paddr[2]
  localparam logic REG_QUANTUM    = 1'b0;
  localparam logic REG_INIT_STACK = 1'b1;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_TERM  = 2'd2,
    OP_KILL  = 2'd3
  } op_t;

  typedef struct packed {
    logic [WORD_W-1:0] quantum;
    logic [WORD_W-1:0] initial_stack;
  } cfg_t;

endpackage

// ----- hdl/rrps_ram.sv -----
`timescale 1ns / 1ps

module rrps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/rrps_cfg.sv -----
`timescale 1ns / 1ps

module rrps_cfg
  import rrps_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t cfg_r;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.quantum       <= QUANTUM_RST;
      cfg_r.initial_stack <= STACK_RST;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_QUANTUM:    cfg_r.quantum       <= pwdata[WORD_W-1:0];
        REG_INIT_STACK: cfg_r.initial_stack <= pwdata[WORD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_QUANTUM:    prdata = CFG_DW'(cfg_r.quantum);
      REG_INIT_STACK: prdata = CFG_DW'(cfg_r.initial_stack);
      default:        prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// ----- hdl/round_robin_process_scheduler_unit.sv -----
`timescale 1ns / 1ps
// Channel | Ports                          | Contents
// --------+--------------------------------+-------------------------------------------
// in      | in_tvalid/tready/tdata/tuser   | one operation per transaction
// out     | out_tvalid/tready/tdata/tuser  | one result per accepted transaction
// cfg     | cfg_psel/penable/pwrite/...    | quantum at 0x0, initial_stack at 0x4
//
// Each item passes two states: accept and stack-table read, then update and result load.
// The stack table read is registered, so the update and result load wait for that read.
// Reset is synchronous; unwritten stack entries read as 0xFF00 through per-entry valid bits.
// A finished result sits in the output register; the next item is taken while it waits,
// and its update holds until that register is free.

module round_robin_process_scheduler_unit
  import rrps_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [39:0]       in_tdata,   // segment_in[15:0], sp_in[31:16], slot_in[34:32]
  input  logic [1:0]        in_tuser,   // op[1:0]
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [39:0]       out_tdata,  // segment_out[15:0], sp_out[31:16], slot_out[34:32]
  output logic [1:0]        out_tuser,  // ok[0], switched[1]
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } st_t;

  cfg_t cfg;

  st_t                 state_r, state_nxt;
  op_t                 op_r;
  logic [WORD_W-1:0]   seg_r, sp_r;
  logic [2:0]          kslot_r;
  logic [SLOT_W-1:0]   next_r, rd_addr_r;
  logic                found_r;

  logic [SLOT_W-1:0]   cur_r, cur_nxt;
  logic [WORD_W-1:0]   tick_r, tick_nxt;
  logic                started_r, started_nxt;
  logic [NUM_SLOTS-1:0] active_r, active_nxt;
  logic [NUM_SLOTS-1:0] stk_vld_r;

  logic                out_valid_r;
  logic [39:0]         out_data_r;
  logic [1:0]          out_user_r;

  logic                in_hs, commit;
  logic                rr_found;
  logic [SLOT_W-1:0]   rr_slot, rd_addr;
  logic                free_found;
  logic [SLOT_W-1:0]   free_slot;
  logic [WORD_W-1:0]   ram_rdata, stack_rd;

  logic                we_c, we;
  logic [SLOT_W-1:0]   waddr;
  logic [WORD_W-1:0]   wdata;

  logic [WORD_W-1:0]   res_seg, res_sp;
  logic [SLOT_W-1:0]   res_slot;
  logic                res_ok, res_sw;

  function automatic logic [WORD_W-1:0] slot_seg(input logic [SLOT_W-1:0] j);
    logic [SLOT_W:0] s;
    s = {1'b0, j} + (SLOT_W+1)'(2);
    return WORD_W'({s, 12'h000});
  endfunction

  rrps_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  rrps_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NUM_SLOTS)
  ) u_stack_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (in_hs),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  assign in_tready = (state_r == ST_IDLE);
  assign in_hs     = in_tvalid & in_tready;
  assign commit    = (state_r == ST_EXEC) && (!out_valid_r || out_tready);

  // next active slot after the current one, cyclic, current slot excluded
  always_comb begin
    logic [SLOT_W:0] sum;
    rr_found = 1'b0;
    rr_slot  = cur_r;
    for (int k = NUM_SLOTS - 1; k >= 1; k--) begin
      sum = {1'b0, cur_r} + (SLOT_W+1)'(k);
      if (sum >= (SLOT_W+1)'(NUM_SLOTS)) begin
        sum = sum - (SLOT_W+1)'(NUM_SLOTS);
      end
      if (active_r[sum[SLOT_W-1:0]]) begin
        rr_found = 1'b1;
        rr_slot  = sum[SLOT_W-1:0];
      end
    end
  end

  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int j = NUM_SLOTS - 1; j >= 0; j--) begin
      if (!active_r[j]) begin
        free_found = 1'b1;
        free_slot  = SLOT_W'(j);
      end
    end
  end

  assign rd_addr  = started_r ? rr_slot : '0;
  assign stack_rd = stk_vld_r[rd_addr_r] ? ram_rdata : STACK_RST;

  always_comb begin
    res_seg     = '0;
    res_sp      = '0;
    res_slot    = '0;
    res_ok      = 1'b0;
    res_sw      = 1'b0;
    we_c        = 1'b0;
    waddr       = cur_r;
    wdata       = cfg.initial_stack;
    cur_nxt     = cur_r;
    tick_nxt    = tick_r;
    started_nxt = started_r;
    active_nxt  = active_r;
    case (op_r)
      OP_TICK: begin
        res_seg = seg_r;
        res_sp  = sp_r;
        if (!started_r) begin
          started_nxt = 1'b1;
          tick_nxt    = tick_r + 1'b1;
          res_seg     = FIRST_SEG;
          res_sp      = stack_rd;
        end else if (tick_r == cfg.quantum) begin
          tick_nxt = '0;
          we_c     = 1'b1;
          wdata    = sp_r;
          if (found_r) begin
            res_seg = slot_seg(next_r);
            res_sp  = stack_rd;
            cur_nxt = next_r;
            res_sw  = 1'b1;
          end
        end else begin
          tick_nxt = tick_r + 1'b1;
        end
        res_slot = cur_nxt;
      end
      OP_ALLOC: begin
        if (free_found) begin
          active_nxt[free_slot] = 1'b1;
          we_c     = 1'b1;
          waddr    = free_slot;
          res_seg  = slot_seg(free_slot);
          res_slot = free_slot;
          res_ok   = 1'b1;
        end
      end
      OP_TERM: begin
        active_nxt[cur_r] = 1'b0;
        we_c = 1'b1;
      end
      OP_KILL: begin
        if (int'(kslot_r) < NUM_SLOTS) begin
          waddr = SLOT_W'(kslot_r);
          active_nxt[waddr] = 1'b0;
          we_c  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign we = commit & we_c;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_hs) state_nxt = ST_EXEC;
      ST_EXEC: if (commit) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cur_r       <= '0;
      tick_r      <= '0;
      started_r   <= 1'b0;
      active_r    <= '0;
      stk_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        cur_r     <= cur_nxt;
        tick_r    <= tick_nxt;
        started_r <= started_nxt;
        active_r  <= active_nxt;
      end
      if (we) begin
        stk_vld_r[waddr] <= 1'b1;
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_hs) begin
      op_r      <= op_t'(in_tuser);
      seg_r     <= in_tdata[15:0];
      sp_r      <= in_tdata[31:16];
      kslot_r   <= in_tdata[34:32];
      next_r    <= rr_slot;
      found_r   <= rr_found;
      rd_addr_r <= rd_addr;
    end
    if (commit) begin
      out_data_r <= {5'b0, 3'(res_slot), res_sp, res_seg};
      out_user_r <= {res_sw, res_ok};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_hs |=> (state_r == ST_EXEC))
    else $error("accepted transaction did not enter execution");

  a_switch_leaves_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && res_sw) |-> (res_slot != cur_r))
    else $error("switch chose the running slot");

  a_alloc_marks_active: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && res_ok) |=> active_r[$past(res_slot)])
    else $error("allocated slot not marked active");

endmodule

// ----- verif/tb_round_robin_process_scheduler_unit.sv -----
`timescale 1ns / 1ps

module tb_round_robin_process_scheduler_unit;
  import rrps_pkg::*;

  localparam int SEG_STEP   = 'h1000;
  localparam int HOLD_LEN   = 400;
  localparam int CYCLE_CAP  = 2_000_000;
  localparam int PHASE_OPS  = 375;

  typedef struct packed {
    logic [WORD_W-1:0] seg;
    logic [WORD_W-1:0] sp;
    logic [SLOT_W-1:0] slot;
    logic              ok;
    logic              switched;
  } reply_t;

  // Mirror of the slot table; one reply queued per accepted transaction.
  class slot_schedule_board;
    logic [WORD_W-1:0] quantum;
    logic [WORD_W-1:0] init_sp;
    logic [WORD_W-1:0] tick_count;
    logic [WORD_W-1:0] stack [NUM_SLOTS];
    bit                active [NUM_SLOTS];
    int unsigned       cur_slot;
    bit                running;
    reply_t            replies_due[$];
    int                mismatches;

    function new();
      quantum    = QUANTUM_RST;
      init_sp    = STACK_RST;
      tick_count = '0;
      cur_slot   = 0;
      running    = 1'b0;
      mismatches = 0;
      foreach (stack[i]) begin
        stack[i]  = STACK_RST;
        active[i] = 1'b0;
      end
    endfunction

    function void set_config(logic [WORD_W-1:0] q, logic [WORD_W-1:0] stk);
      quantum = q;
      init_sp = stk;
    endfunction

    function logic [WORD_W-1:0] seg_of(int unsigned j);
      return WORD_W'((j + 2) * SEG_STEP);
    endfunction

    function void free_slot(int unsigned j);
      if (j < NUM_SLOTS) begin
        active[j] = 1'b0;
        stack[j]  = init_sp;
      end
    endfunction

    function void accept_op(op_t op, logic [WORD_W-1:0] seg, logic [WORD_W-1:0] sp,
                            logic [SLOT_W-1:0] slot);
      reply_t      r;
      int unsigned start;
      int unsigned j;
      r = '0;
      case (op)
        OP_TICK: begin
          r.seg = seg;
          r.sp  = sp;
          if (!running) begin
            running = 1'b1;
            tick_count++;
            r.seg = FIRST_SEG;
            r.sp  = stack[0];
          end else if (tick_count == quantum) begin
            tick_count = '0;
            stack[cur_slot] = sp;
            start = cur_slot;
            for (int k = 1; k < NUM_SLOTS; k++) begin
              j = (start + k) % NUM_SLOTS;
              if (active[j] && !r.switched) begin
                r.seg      = seg_of(j);
                r.sp       = stack[j];
                cur_slot   = j;
                r.switched = 1'b1;
              end
            end
          end else begin
            tick_count++;
          end
          r.slot = SLOT_W'(cur_slot);
        end
        OP_ALLOC: begin
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (!active[i] && !r.ok) begin
              active[i] = 1'b1;
              stack[i]  = init_sp;
              r.seg     = seg_of(i);
              r.slot    = SLOT_W'(i);
              r.ok      = 1'b1;
            end
          end
        end
        OP_TERM: free_slot(cur_slot);
        OP_KILL: free_slot(slot);
      endcase
      replies_due.push_back(r);
    endfunction

    function void compare(string field, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
      if (got !== want) begin
        mismatches++;
        $display("%0t: %s expected %h got %h", $time, field, want, got);
      end
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      if (replies_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected transaction seg %h sp %h slot %0d ok %b switched %b",
                 $time, got.seg, got.sp, got.slot, got.ok, got.switched);
        return;
      end
      want = replies_due.pop_front();
      compare("segment_out", want.seg, got.seg);
      compare("sp_out", want.sp, got.sp);
      compare("slot_out", want.slot, got.slot);
      compare("ok", want.ok, got.ok);
      compare("switched", want.switched, got.switched);
    endfunction
  endclass

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              in_tvalid   = 1'b0;
  logic              in_tready;
  logic [39:0]       in_tdata    = '0;   // segment_in[15:0], sp_in[31:16], slot_in[34:32]
  logic [1:0]        in_tuser    = '0;   // op[1:0]
  logic              out_tvalid;
  logic              out_tready  = 1'b0;
  logic [39:0]       out_tdata;          // segment_out[15:0], sp_out[31:16], slot_out[34:32]
  logic [1:0]        out_tuser;          // ok[0], switched[1]
  logic              cfg_psel    = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr   = '0;
  logic [CFG_DW-1:0] cfg_pwdata  = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  slot_schedule_board board = new();
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_left     = 0;
  bit hold_req      = 1'b0;
  int cycles        = 0;

  round_robin_process_scheduler_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver: checks each result transaction, stalls at random or for a long hold
  always @(posedge clk) begin
    if (out_tvalid && out_tready)
      board.check_reply(reply_t'({out_tdata[15:0], out_tdata[31:16], out_tdata[34:32],
                                  out_tuser[0], out_tuser[1]}));
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return WORD_W'($urandom);
    endcase
  endfunction

  task automatic send_item(input op_t op, input logic [WORD_W-1:0] seg,
                           input logic [WORD_W-1:0] sp, input logic [SLOT_W-1:0] slot);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {5'b0, slot, sp, seg};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.accept_op(op, seg, sp, slot);
  endtask

  task automatic send_tick();
    send_item(OP_TICK, rand_word(), rand_word(), SLOT_W'($urandom_range(NUM_SLOTS - 1)));
  endtask

  task automatic run_to_expiry();
    while (board.tick_count != board.quantum) send_tick();
    send_tick();
  endtask

  task automatic random_item();
    int unsigned pick;
    op_t op;
    pick = $urandom_range(99);
    if (pick < 50)      op = OP_TICK;
    else if (pick < 72) op = OP_ALLOC;
    else if (pick < 82) op = OP_TERM;
    else                op = OP_KILL;
    send_item(op, rand_word(), rand_word(), SLOT_W'($urandom_range(NUM_SLOTS - 1)));
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (board.replies_due.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_apply(input logic [WORD_W-1:0] q, input logic [WORD_W-1:0] stk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {REG_QUANTUM, 2'b00};
    cfg_pwdata  <= CFG_DW'(q);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_penable <= 1'b0;
    cfg_paddr   <= {REG_INIT_STACK, 2'b00};
    cfg_pwdata  <= CFG_DW'(stk);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    board.set_config(q, stk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // first tick at reset settings
    send_item(OP_ALLOC, 16'h0000, 16'h0000, 3'd0);
    send_item(OP_TICK, 16'hFFFF, 16'hFFFF, 3'd7);
    drain();
    cfg_apply(16'd1, 16'hFFFF);
    send_item(OP_TICK, 16'h1234, 16'h0000, 3'd0);   // expiry, nobody else runnable
    send_item(OP_TICK, 16'h0000, 16'hFFFF, 3'd0);
    repeat (8) send_item(OP_ALLOC, 16'hFFFF, 16'hFFFF, 3'd7);   // last one finds table full
    send_item(OP_TICK, 16'hFFFF, 16'h0000, 3'd0);
    send_item(OP_KILL, 16'h0000, 16'h0000, 3'd0);
    send_item(OP_KILL, 16'hFFFF, 16'hFFFF, 3'd7);
    send_item(OP_TERM, 16'h5555, 16'hAAAA, 3'd2);
    send_item(OP_TICK, 16'hAAAA, 16'h5555, 3'd0);
    send_item(OP_TICK, 16'h0F0F, 16'hF0F0, 3'd0);
    drain();
    cfg_apply(16'd0, 16'h0000);
    send_item(OP_TICK, 16'h0001, 16'h8000, 3'd0);
    send_item(OP_TICK, 16'h8000, 16'h0001, 3'd0);
    send_item(OP_ALLOC, 16'h0000, 16'h0000, 3'd0);
    send_item(OP_KILL, 16'h0000, 16'h0000, 3'd5);
    send_item(OP_KILL, 16'h0000, 16'h0000, 3'd6);
    send_item(OP_TICK, 16'hC3C3, 16'h3C3C, 3'd0);   // search wraps round to slot 0
    drain();

    // tick counter runs past the quantum
    cfg_apply(16'hFFFF, 16'h8001);
    send_tick();
    send_tick();
    drain();
    cfg_apply(16'd1, rand_word());
    repeat (3) send_tick();
    drain();
    cfg_apply(board.tick_count + 16'd2, rand_word());
    run_to_expiry();

    for (int ph = 0; ph < 4; ph++) begin
      drain();
      case (ph)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
          cfg_apply(16'd1, rand_word());
          hold_req = 1'b1;
        end
        1: begin
          send_idle_pct = 68;
          stall_pct     = 0;
          cfg_apply(16'd3, STACK_RST);
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 68;
          cfg_apply(16'd6, rand_word());
        end
        default: begin
          send_idle_pct = 31;
          stall_pct     = 31;
          cfg_apply(QUANTUM_RST, rand_word());
        end
      endcase
      for (int n = 0; n < PHASE_OPS; n++) begin
        random_item();
        if (ph == 2 && n == PHASE_OPS / 2) drain();
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (board.mismatches == 0 && board.replies_due.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
